@@ rtl/sqbe_pkg.sv @@
`timescale 1ns / 1ps
package sqbe_pkg;

	localparam int DEPTH = 32;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [31:0] CHAR_MAX_CODE = 32'd127;

	typedef enum logic [4:0] {
		ACT_PUSH = 5'd0, ACT_PALL = 5'd1, ACT_PINT = 5'd2, ACT_POP = 5'd3,
		ACT_SWAP = 5'd4, ACT_ADD = 5'd5, ACT_NOP = 5'd6, ACT_SUB = 5'd7,
		ACT_DIV = 5'd8, ACT_MUL = 5'd9, ACT_MOD = 5'd10, ACT_PCHAR = 5'd11,
		ACT_PSTR = 5'd12, ACT_ROTL = 5'd13, ACT_ROTR = 5'd14,
		ACT_STACK = 5'd15, ACT_QUEUE = 5'd16
	} action_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_EMPTY = 3'd1, ST_SHORT = 3'd2, ST_DIVZ = 3'd3,
		ST_CHAR = 3'd4, ST_FULL = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		K_ACK = 2'd0, K_INT = 2'd1, K_CHAR = 2'd2, K_EOL = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		S_IDLE, S_RDA, S_RDB, S_WAITB, S_EXEC, S_DIV, S_WRITE, S_WALK, S_WALKD,
		S_EMIT
	} state_t;

	// Control between sequencer and divider.
	typedef struct packed {
		logic start;
		logic is_mod;
	} div_ctl_t;

endpackage

@@ rtl/sqbe_ram.sv @@
`timescale 1ns / 1ps
module sqbe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH_W = 32
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH_W)-1:0] waddr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic [$clog2(DEPTH_W)-1:0] raddr,
	output logic [WIDTH-1:0]           rdata
);
	logic [WIDTH-1:0] mem [DEPTH_W];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/sqbe_div.sv @@
`timescale 1ns / 1ps
module sqbe_div import sqbe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  div_ctl_t    ctl,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] result
);
	logic [31:0] rem_q, quo_q, dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q, nq_q, nr_q, mod_q;
	logic [32:0] trial;
	logic [31:0] rem_sh;

	// One restoring step per cycle on magnitudes.
	assign rem_sh = {rem_q[30:0], quo_q[31]};
	assign trial = {1'b0, rem_sh} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= '0;
			quo_q <= dividend[31] ? -dividend : dividend;
			dvs_q <= divisor[31] ? -divisor : divisor;
			nq_q <= dividend[31] ^ divisor[31];
			nr_q <= dividend[31];
			mod_q <= ctl.is_mod;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	// Sign fixup; wraps for the minimum value over minus one.
	always_comb begin
		if (mod_q) begin
			result = nr_q ? -rem_q : rem_q;
		end else begin
			result = nq_q ? -quo_q : quo_q;
		end
	end
endmodule

@@ rtl/stack_queue_bytecode_engine.sv @@
`timescale 1ns / 1ps
// Stack/queue bytecode engine: each input beat carries one instruction that
// works on a deque of up to 32 signed 32-bit entries kept in a ring RAM. One
// instruction at a time is executed; s_tready is high only in the idle state,
// which is reached once the last result beat of the previous instruction has
// been loaded into the output register. Div and mod run in the shared 32-step
// restoring divider, and pall/pstr read each entry walked in turn (S_WALK,
// then S_WALKD), since each entry is read through the one RAM read port.
// Results leave through one output register, with m_tlast on the final beat
// of each instruction; a stalled output holds the sequencer in place.
module stack_queue_bytecode_engine import sqbe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // [4:0] action, [36:5] operand, zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [2:0] status, [4:3] kind, [36:5] value
	output logic        m_tlast
);
	state_t state_q, state_d;
	logic [4:0]    act_q;
	logic [31:0]   opd_q, a_q, b_q, r_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] cnt_q;
	logic          qmode_q;
	logic [2:0]    ost_q;
	logic [1:0]    okind_q;
	logic [31:0]   oval_q;
	logic          olast_q, ov_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [31:0]   wdata, rdata;
	div_ctl_t      dctl;
	logic          ddone;
	logic [31:0]   dres;
	logic          out_free;

	sqbe_ram #(.WIDTH(32), .DEPTH_W(DEPTH)) u_ram (
		.clk, .we, .waddr, .wdata, .raddr, .rdata
	);
	sqbe_div u_div (
		.clk, .arst_n, .ctl(dctl), .dividend(b_q), .divisor(a_q),
		.done(ddone), .result(dres)
	);

	logic [AW-1:0] head_p1, head_m1, tail;
	assign head_p1 = head_q + AW'(1);
	assign head_m1 = head_q - AW'(1);
	assign tail = head_q + cnt_q[AW-1:0];
	assign out_free = !ov_q || m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = ov_q;
	assign m_tdata = {3'b000, oval_q, okind_q, ost_q};
	assign m_tlast = olast_q;

	logic fetch_ok, walk_more, walk_char;
	assign fetch_ok = s_tvalid && s_tready;
	assign walk_more = idx_q < cnt_q;
	assign walk_char = !rdata[31] && rdata != 32'd0 && rdata <= CHAR_MAX_CODE;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (fetch_ok) state_d = S_RDA;
			S_RDA: begin
				case (act_q)
					ACT_PINT, ACT_PCHAR, ACT_SWAP, ACT_ADD, ACT_SUB, ACT_MUL,
					ACT_DIV, ACT_MOD, ACT_ROTL, ACT_ROTR: state_d = S_RDB;
					ACT_PALL, ACT_PSTR: state_d = S_WALK;
					default: state_d = S_EMIT;
				endcase
			end
			S_RDB: state_d = S_WAITB;
			S_WAITB: state_d = S_EXEC;
			S_EXEC: state_d = S_WRITE;
			S_DIV: if (ddone) state_d = S_WRITE;
			S_WRITE: state_d = S_EMIT;
			S_WALK: state_d = S_WALKD;
			S_WALKD: state_d = S_EMIT;
			S_EMIT: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
		if (state_q == S_EXEC && (act_q == ACT_DIV || act_q == ACT_MOD)
		    && cnt_q >= CW'(2) && a_q != 32'd0) begin
			state_d = S_DIV;
		end
		if (state_q == S_WALKD && walk_more && out_free
		    && (act_q == ACT_PALL || walk_char)) begin
			state_d = S_WALK;
		end
		if (state_q == S_WALKD && !out_free) state_d = S_WALKD;
	end

	// RAM addresses, write port and divider start.
	always_comb begin
		raddr = head_q;
		case (state_q)
			S_RDA: raddr = head_q;
			S_RDB: raddr = (act_q == ACT_ROTR) ? tail - AW'(1) : head_p1;
			// The walk address is held while waiting so the read data stays valid.
			S_WALK, S_WALKD: raddr = head_q + idx_q[AW-1:0];
			default: raddr = head_q;
		endcase
		dctl.start = (state_q == S_EXEC) && (state_d == S_DIV);
		dctl.is_mod = (act_q == ACT_MOD);
		we = 1'b0;
		waddr = head_p1;
		wdata = r_q;
		if (state_q == S_RDA && act_q == ACT_PUSH && {1'b0, cnt_q} < (CW + 1)'(DEPTH)) begin
			we = 1'b1;
			waddr = qmode_q ? tail : head_m1;
			wdata = opd_q;
		end
		if (state_q == S_WRITE && cnt_q >= CW'(2)) begin
			case (act_q)
				ACT_SWAP: begin we = 1'b1; waddr = head_q; wdata = b_q; end
				ACT_ADD, ACT_SUB, ACT_MUL: we = 1'b1;
				ACT_DIV, ACT_MOD: we = (a_q != 32'd0);
				ACT_ROTL: begin we = 1'b1; waddr = tail; wdata = a_q; end
				ACT_ROTR: begin we = 1'b1; waddr = head_m1; wdata = b_q; end
				default: we = 1'b0;
			endcase
		end
		if (state_q == S_EMIT && act_q == ACT_SWAP && cnt_q >= CW'(2)) begin
			we = 1'b1;
			waddr = head_p1;
			wdata = a_q;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			cnt_q <= '0;
			qmode_q <= 1'b0;
			ov_q <= 1'b0;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (m_tready) ov_q <= 1'b0;
			if (state_q == S_IDLE) idx_q <= '0;
			case (state_q)
				S_RDA: begin
					if (act_q == ACT_PUSH && {1'b0, cnt_q} < (CW + 1)'(DEPTH)) begin
						cnt_q <= cnt_q + CW'(1);
						if (!qmode_q) head_q <= head_m1;
					end
					if (act_q == ACT_POP && cnt_q != '0) begin
						cnt_q <= cnt_q - CW'(1);
						head_q <= head_p1;
					end
					if (act_q == ACT_STACK) qmode_q <= 1'b0;
					if (act_q == ACT_QUEUE) qmode_q <= 1'b1;
				end
				S_WRITE: begin
					if (cnt_q >= CW'(2)) begin
						case (act_q)
							ACT_ADD, ACT_SUB, ACT_MUL: begin
								head_q <= head_p1;
								cnt_q <= cnt_q - CW'(1);
							end
							ACT_DIV, ACT_MOD: if (a_q != 32'd0) begin
								head_q <= head_p1;
								cnt_q <= cnt_q - CW'(1);
							end
							ACT_ROTL: head_q <= head_p1;
							ACT_ROTR: head_q <= head_m1;
							default: ;
						endcase
					end
				end
				S_WALKD: if (out_free) begin
					if (walk_more && (act_q == ACT_PALL || walk_char)) begin
						ov_q <= 1'b1;
						idx_q <= idx_q + CW'(1);
					end
				end
				S_EMIT: if (out_free) begin
					ov_q <= !(act_q == ACT_PALL && idx_q != '0);
				end
				default: ;
			endcase
		end
	end

	// Payload registers and the result held for the output beat.
	logic [2:0]  est;
	logic [1:0]  ekind;
	logic [31:0] eval;
	always_comb begin
		est = ST_OK; ekind = K_ACK; eval = '0;
		case (act_q)
			ACT_PUSH: if (r_q[0]) est = ST_FULL;
			ACT_PINT, ACT_POP: if (r_q[1]) est = ST_EMPTY;
				else if (act_q == ACT_PINT) begin ekind = K_INT; eval = a_q; end
			ACT_PCHAR: if (r_q[1]) est = ST_EMPTY;
				else if (a_q[31] || a_q > CHAR_MAX_CODE) est = ST_CHAR;
				else begin ekind = K_CHAR; eval = a_q; end
			ACT_SWAP, ACT_ADD, ACT_SUB, ACT_MUL: if (r_q[2]) est = ST_SHORT;
			ACT_DIV, ACT_MOD: if (r_q[2]) est = ST_SHORT;
				else if (r_q[3]) est = ST_DIVZ;
			ACT_PSTR: ekind = K_EOL;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (fetch_ok) begin
			act_q <= s_tdata[4:0];
			opd_q <= s_tdata[36:5];
			r_q <= '0;
		end
		// Error flags are captured in r_q before any state change.
		if (state_q == S_RDA && (act_q == ACT_PUSH || act_q == ACT_POP)) begin
			r_q <= {28'd0, 1'b0, 1'b0, cnt_q == '0, {1'b0, cnt_q} >= (CW + 1)'(DEPTH)};
		end
		if (state_q == S_RDB) a_q <= rdata;
		if (state_q == S_WAITB) b_q <= rdata;
		if (state_q == S_EXEC) begin
			case (act_q)
				ACT_ADD: r_q <= b_q + a_q;
				ACT_SUB: r_q <= b_q - a_q;
				ACT_MUL: r_q <= b_q * a_q;
				ACT_PINT, ACT_PCHAR: r_q <= {30'd0, cnt_q == '0, 1'b0};
				default: r_q <= {28'd0, a_q == 32'd0, cnt_q < CW'(2), 2'b00};
			endcase
		end
		if (state_q == S_DIV && ddone) r_q <= dres;
		if (state_q == S_WRITE && act_q != ACT_ADD && act_q != ACT_SUB
		    && act_q != ACT_MUL && act_q != ACT_DIV && act_q != ACT_MOD) begin
			r_q <= r_q;
		end
		if (state_q == S_WRITE && (act_q == ACT_ADD || act_q == ACT_SUB
		    || act_q == ACT_MUL || ((act_q == ACT_DIV || act_q == ACT_MOD)))) begin
			r_q <= {28'd0, a_q == 32'd0, cnt_q < CW'(2), 2'b00};
		end
		if (state_q == S_WALKD && out_free && walk_more
		    && (act_q == ACT_PALL || walk_char)) begin
			ost_q <= ST_OK;
			okind_q <= (act_q == ACT_PALL) ? K_INT : K_CHAR;
			oval_q <= rdata;
			olast_q <= (act_q == ACT_PALL) && (idx_q + CW'(1) == cnt_q);
		end
		if (state_q == S_EMIT && out_free) begin
			ost_q <= est;
			okind_q <= ekind;
			oval_q <= eval;
			olast_q <= 1'b1;
		end
	end
endmodule

@@ dv/stack_queue_bytecode_engine_test.sv @@
`timescale 1ns / 1ps
module stack_queue_bytecode_engine_test;
	import sqbe_pkg::*;

	localparam logic [4:0]  UNUSED_ACTION = 5'd31;
	localparam logic [31:0] INT_MIN       = 32'h8000_0000;
	localparam logic [31:0] INT_MAX       = 32'h7FFF_FFFF;
	localparam logic [31:0] MINUS_ONE     = 32'hFFFF_FFFF;
	localparam int          CYCLE_LIMIT   = 1_500_000;
	localparam int          LONG_HOLD     = 400;

	typedef struct {
		status_t     st;
		kind_t       kd;
		logic [31:0] val;
		logic        lst;
	} beat_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        m_tlast;

	// Shadow copy of the deque kept by the predictor.
	logic [31:0] shadow_ring [DEPTH];
	logic [AW-1:0] shadow_head;
	int          shadow_count;
	logic        shadow_queue_mode;

	beat_t       pending_beats [$];
	int          error_count;
	int          cycle_count;
	bit          send_idle_on;
	bit          recv_idle_on;
	bit          hold_request;

	stack_queue_bytecode_engine i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// Clock with an 8 ns period.
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Run watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic logic [AW-1:0] ring_slot(int offset);
		ring_slot = AW'((shadow_head + offset) % DEPTH);
	endfunction

	function automatic void add_beat(status_t st, kind_t kd, logic [31:0] val);
		beat_t b;
		b.st  = st;
		b.kd  = kd;
		b.val = val;
		b.lst = 1'b0;
		pending_beats.push_back(b);
	endfunction

	// Work out the result beats of one instruction and update the shadow deque.
	function automatic void execute_instruction(logic [4:0] act, logic [31:0] operand);
		logic [31:0] a, b, r, t;
		logic signed [31:0] v;
		int i;
		case (act)
			ACT_PUSH: begin
				if (shadow_count >= DEPTH) begin
					add_beat(ST_FULL, K_ACK, '0);
				end else begin
					if (shadow_queue_mode) begin
						shadow_ring[ring_slot(shadow_count)] = operand;
					end else begin
						shadow_head = shadow_head - 1'b1;
						shadow_ring[shadow_head] = operand;
					end
					shadow_count++;
					add_beat(ST_OK, K_ACK, '0);
				end
			end
			ACT_PALL: begin
				for (i = 0; i < shadow_count; i++)
					add_beat(ST_OK, K_INT, shadow_ring[ring_slot(i)]);
				if (shadow_count == 0)
					add_beat(ST_OK, K_ACK, '0);
			end
			ACT_PINT: begin
				if (shadow_count == 0)
					add_beat(ST_EMPTY, K_ACK, '0);
				else
					add_beat(ST_OK, K_INT, shadow_ring[shadow_head]);
			end
			ACT_POP: begin
				if (shadow_count == 0) begin
					add_beat(ST_EMPTY, K_ACK, '0);
				end else begin
					shadow_head = ring_slot(1);
					shadow_count--;
					add_beat(ST_OK, K_ACK, '0);
				end
			end
			ACT_SWAP, ACT_ADD, ACT_SUB, ACT_DIV, ACT_MUL, ACT_MOD: begin
				if (shadow_count < 2) begin
					add_beat(ST_SHORT, K_ACK, '0);
				end else begin
					a = shadow_ring[shadow_head];
					b = shadow_ring[ring_slot(1)];
					if (act == ACT_SWAP) begin
						shadow_ring[shadow_head] = b;
						shadow_ring[ring_slot(1)] = a;
						add_beat(ST_OK, K_ACK, '0);
					end else if ((act == ACT_DIV || act == ACT_MOD) && a == 0) begin
						add_beat(ST_DIVZ, K_ACK, '0);
					end else begin
						case (act)
							ACT_ADD: r = b + a;
							ACT_SUB: r = b - a;
							ACT_MUL: r = b * a;
							ACT_DIV: r = (b == INT_MIN && a == MINUS_ONE) ? INT_MIN :
								32'($signed(b) / $signed(a));
							default: r = (b == INT_MIN && a == MINUS_ONE) ? '0 :
								32'($signed(b) % $signed(a));
						endcase
						shadow_ring[ring_slot(1)] = r;
						shadow_head = ring_slot(1);
						shadow_count--;
						add_beat(ST_OK, K_ACK, '0);
					end
				end
			end
			ACT_PCHAR: begin
				if (shadow_count == 0) begin
					add_beat(ST_EMPTY, K_ACK, '0);
				end else begin
					v = shadow_ring[shadow_head];
					if (v < 0 || v > $signed(CHAR_MAX_CODE))
						add_beat(ST_CHAR, K_ACK, '0);
					else
						add_beat(ST_OK, K_CHAR, v);
				end
			end
			ACT_PSTR: begin
				for (i = 0; i < shadow_count; i++) begin
					v = shadow_ring[ring_slot(i)];
					if (v <= 0 || v > $signed(CHAR_MAX_CODE))
						break;
					add_beat(ST_OK, K_CHAR, v);
				end
				add_beat(ST_OK, K_EOL, '0);
			end
			ACT_ROTL: begin
				if (shadow_count >= 2) begin
					t = shadow_ring[shadow_head];
					shadow_ring[ring_slot(shadow_count)] = t;
					shadow_head = ring_slot(1);
				end
				add_beat(ST_OK, K_ACK, '0);
			end
			ACT_ROTR: begin
				if (shadow_count >= 2) begin
					t = shadow_ring[ring_slot(shadow_count - 1)];
					shadow_head = shadow_head - 1'b1;
					shadow_ring[shadow_head] = t;
				end
				add_beat(ST_OK, K_ACK, '0);
			end
			ACT_STACK: begin
				shadow_queue_mode = 1'b0;
				add_beat(ST_OK, K_ACK, '0);
			end
			ACT_QUEUE: begin
				shadow_queue_mode = 1'b1;
				add_beat(ST_OK, K_ACK, '0);
			end
			default: add_beat(ST_OK, K_ACK, '0);
		endcase
		pending_beats[pending_beats.size() - 1].lst = 1'b1;
	endfunction

	// Offer one instruction beat and wait until it is taken.
	task automatic send_instruction(logic [4:0] act, logic [31:0] operand = '0);
		int gap;
		gap = send_idle_on ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, operand, act};
		do @(posedge clk); while (!s_tready);
		execute_instruction(act, operand);
		@(negedge clk);
	endtask

	// Result side: random stalls, and one long hold when asked.
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				stall = LONG_HOLD;
				hold_request = 1'b0;
			end else begin
				stall = recv_idle_on ? $urandom_range(0, 16) : 0;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Compare each result beat with the oldest expectation.
	always @(posedge clk) begin
		beat_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_beats.size() == 0) begin
				$display("%0t: unexpected result beat %h last %b", $realtime, m_tdata, m_tlast);
				error_count++;
			end else begin
				e = pending_beats.pop_front();
				if (m_tdata[2:0] !== e.st) begin
					$display("%0t: status expected %0d actual %0d", $realtime, e.st,
						m_tdata[2:0]);
					error_count++;
				end
				if (m_tdata[4:3] !== e.kd) begin
					$display("%0t: kind expected %0d actual %0d", $realtime, e.kd,
						m_tdata[4:3]);
					error_count++;
				end
				if (m_tdata[36:5] !== e.val) begin
					$display("%0t: value expected %h actual %h", $realtime, e.val,
						m_tdata[36:5]);
					error_count++;
				end
				if (m_tdata[39:37] !== 3'b000) begin
					$display("%0t: fill bits expected 0 actual %b", $realtime, m_tdata[39:37]);
					error_count++;
				end
				if (m_tlast !== e.lst) begin
					$display("%0t: last expected %b actual %b", $realtime, e.lst, m_tlast);
					error_count++;
				end
			end
		end
	end

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 5))
			0:       pick_operand = $urandom_range(1, 127);
			1:       pick_operand = $urandom_range(0, 1) ? INT_MIN : INT_MAX;
			2:       pick_operand = MINUS_ONE - $urandom_range(0, 3);
			3:       pick_operand = $urandom_range(0, 300);
			default: pick_operand = $urandom;
		endcase
	endfunction

	// Error cases on short and empty deques, and the edge values.
	task automatic test_corner_cases();
		send_instruction(ACT_PALL);
		send_instruction(ACT_PINT);
		send_instruction(ACT_POP);
		send_instruction(ACT_PCHAR);
		send_instruction(ACT_PSTR);
		send_instruction(ACT_ROTL);
		send_instruction(ACT_PUSH, INT_MIN);
		send_instruction(ACT_ADD);
		send_instruction(ACT_ROTR);
		send_instruction(ACT_PCHAR);
		send_instruction(ACT_PUSH, MINUS_ONE);
		send_instruction(ACT_DIV);
		send_instruction(ACT_PUSH, INT_MIN);
		send_instruction(ACT_PUSH, MINUS_ONE);
		send_instruction(ACT_MOD);
		send_instruction(ACT_PUSH, 32'd0);
		send_instruction(ACT_DIV);
		send_instruction(ACT_PUSH, 32'd128);
		send_instruction(ACT_PCHAR);
		send_instruction(ACT_PUSH, INT_MAX);
		send_instruction(ACT_SWAP);
		send_instruction(UNUSED_ACTION, INT_MAX);
		send_instruction(ACT_NOP);
		send_instruction(ACT_PALL);
	endtask

	// Queue mode with characters, then fill the ring while the output is held off.
	task automatic test_full_under_backpressure();
		int i;
		send_instruction(ACT_QUEUE);
		for (i = 0; i < 4; i++)
			send_instruction(ACT_PUSH, 32'd72 + i);
		send_instruction(ACT_PSTR);
		send_instruction(ACT_ROTL);
		send_instruction(ACT_ROTR);
		send_instruction(ACT_MUL);
		send_instruction(ACT_SUB);
		send_instruction(ACT_STACK);
		hold_request = 1'b1;
		for (i = 0; i < DEPTH + 2; i++)
			send_instruction(ACT_PUSH, $urandom_range(1, 127));
		send_instruction(ACT_PSTR);
		send_instruction(ACT_PALL);
		while (shadow_count > 0)
			send_instruction(ACT_POP);
	endtask

	// Random programs, mostly well formed, with and without idling.
	task automatic test_random_programs(int count);
		int i, sel;
		logic [4:0] act;
		for (i = 0; i < count; i++) begin
			if (i == count / 3) begin
				send_idle_on = 1'b0;
				recv_idle_on = 1'b0;
			end else if (i == count / 2) begin
				send_idle_on = 1'b1;
				recv_idle_on = 1'b1;
			end
			sel = $urandom_range(0, 99);
			if (sel < 40 && shadow_count < DEPTH - 2)
				act = ACT_PUSH;
			else if (sel < 90)
				act = 5'($urandom_range(ACT_PUSH, ACT_QUEUE));
			else
				act = 5'($urandom_range(0, 31));
			send_instruction(act, pick_operand());
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		error_count   = 0;
		cycle_count   = 0;
		send_idle_on  = 1'b1;
		recv_idle_on  = 1'b1;
		hold_request  = 1'b0;
		shadow_head   = '0;
		shadow_count  = 0;
		shadow_queue_mode = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_corner_cases();
		test_full_under_backpressure();
		test_random_programs(250);
		s_tvalid <= 1'b0;

		// Drain, then give the block time to show any extra beat.
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (error_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/sqbe_pkg.sv
rtl/sqbe_ram.sv
rtl/sqbe_div.sv
rtl/stack_queue_bytecode_engine.sv
dv/stack_queue_bytecode_engine_test.sv
